FILE: src/tdpt_pkg.sv
package tdpt_pkg;

  localparam int unsigned NumW = 32;
  localparam int unsigned Width = 32;
  localparam int unsigned CntW = $clog2(Width);

  localparam logic [Width-1:0] FirstDivisor = Width'(3);
  localparam logic [Width-1:0] DivisorStep = Width'(2);
  localparam logic [Width-1:0] SmallestPrime = Width'(2);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_CHECK,
    ST_REPORT
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic start;
    logic step;
    logic advance;
  } dp_cmd_t;

  typedef struct packed {
    logic trivial;
    logic trivial_prime;
    logic last_step;
    logic q_lt_d;
    logic r_zero;
  } dp_status_t;

endpackage

FILE: src/tdpt_num_if.sv
interface tdpt_num_if
  import tdpt_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [NumW-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink (input valid, input number, output ready);
endinterface

FILE: src/tdpt_res_if.sv
interface tdpt_res_if;
  logic valid;
  logic ready;
  logic is_prime;

  modport source (output valid, output is_prime, input ready);
  modport sink (input valid, input is_prime, output ready);
endinterface

FILE: src/trial_division_prime_test.sv
// Tests one unsigned number per input transaction by trial division and returns
// one result transaction with is_prime set when the number is prime. Numbers
// below two and all even numbers, two among them, are answered without division.
// An odd number from three upward is divided by 3, 5, 7, ... in turn by a
// bit-serial restoring divider that takes one quotient bit per cycle; for each
// divisor it starts the divider, runs Width division steps and checks.
// The number of divisors tried is about 32768 for 32-bit primes near the
// top of the range. A new number is accepted while a finished result still
// waits in the output register.
module trial_division_prime_test
  import tdpt_pkg::*;
(
  input logic         clk_i,
  input logic         rst_ni,
  tdpt_num_if.sink    num_i,
  tdpt_res_if.source  res_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  tdpt_controller u_controller (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (num_i.valid),
    .in_ready_o  (num_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .is_prime_o  (res_o.is_prime),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tdpt_datapath u_datapath (
    .clk_i    (clk_i),
    .number_i (num_i.number),
    .cmd_i    (cmd),
    .status_o (status)
  );

endmodule

FILE: src/tdpt_datapath.sv
module tdpt_datapath
  import tdpt_pkg::*;
(
  input  logic            clk_i,
  input  logic [NumW-1:0] number_i,
  input  dp_cmd_t         cmd_i,
  output dp_status_t      status_o
);

  logic [Width-1:0] n_q, n_d;
  logic [Width-1:0] d_q, d_d;
  logic [Width-1:0] rem_q, rem_d;
  logic [Width-1:0] quo_q, quo_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [Width:0]   trial;
  logic [Width:0]   diff;
  logic             ge;

  assign trial = {rem_q, quo_q[Width-1]};
  assign diff  = trial - {1'b0, d_q};
  assign ge    = trial >= {1'b0, d_q};

  always_comb begin
    n_d   = n_q;
    d_d   = d_q;
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      n_d = Width'(number_i);
      d_d = FirstDivisor;
    end
    if (cmd_i.start) begin
      rem_d = '0;
      quo_d = n_q;
      cnt_d = '0;
    end
    if (cmd_i.step) begin
      rem_d = ge ? diff[Width-1:0] : trial[Width-1:0];
      quo_d = {quo_q[Width-2:0], ge};
      cnt_d = cnt_q + CntW'(1);
    end
    if (cmd_i.advance) begin
      d_d = d_q + DivisorStep;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    d_q   <= d_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    cnt_q <= cnt_d;
  end

  assign status_o.trivial       = (n_q < SmallestPrime) || !n_q[0];
  assign status_o.trivial_prime = n_q == SmallestPrime;
  assign status_o.last_step     = cnt_q == CntW'(Width - 1);
  assign status_o.q_lt_d        = quo_q < d_q;
  assign status_o.r_zero        = rem_q == '0;

endmodule

FILE: src/tdpt_controller.sv
module tdpt_controller
  import tdpt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       is_prime_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        verdict_q, verdict_d;
  logic        out_valid_q, out_valid_d;
  logic        is_prime_q, is_prime_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      verdict_q   <= 1'b0;
      out_valid_q <= 1'b0;
      is_prime_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      verdict_q   <= verdict_d;
      out_valid_q <= out_valid_d;
      is_prime_q  <= is_prime_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    verdict_d   = verdict_q;
    out_valid_d = out_valid_q && !out_ready_i;
    is_prime_d  = is_prime_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_START;
        end
      end
      ST_START: begin
        if (status_i.trivial) begin
          verdict_d = status_i.trivial_prime;
          state_d   = ST_REPORT;
        end else begin
          cmd_o.start = 1'b1;
          state_d     = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        if (status_i.last_step) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        priority if (status_i.q_lt_d) begin
          verdict_d = 1'b1;
          state_d   = ST_REPORT;
        end else if (status_i.r_zero) begin
          verdict_d = 1'b0;
          state_d   = ST_REPORT;
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = ST_START;
        end
      end
      ST_REPORT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          is_prime_d  = verdict_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign is_prime_o  = is_prime_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.start, cmd_o.step, cmd_o.advance}))
    else $error("More than one datapath command is active.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && status_i.last_step) |=> state_q == ST_CHECK)
    else $error("The division did not end in the check state.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_REPORT)
    else $error("A result appeared without a report step.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == ST_START)
    else $error("An accepted transaction did not start a test.");

endmodule
